### hw/rtl/tccs_pkg.sv
// Package for the text console cursor and scroll core.
// Holds character codes, command codes, register indexes and the result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

    // ring size and line stride
    localparam int MAX_ROWS    = 64;
    localparam int LINE_STRIDE = 84;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = 7;
    localparam int CHAR_W      = 8;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;

    // clamp limits of the configuration registers
    localparam logic [CFG_W-1:0] ROWS_MIN = CFG_W'(2);
    localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] COLS_MIN = CFG_W'(1);
    localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(LINE_STRIDE);

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] ROWS_RST = CFG_W'(24);
    localparam logic [CFG_W-1:0] COLS_RST = CFG_W'(80);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = CFG_IDX_W'(1);

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'd12;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    // drawing commands
    typedef enum logic [2:0] {
        OP_MOVE   = 3'd0,
        OP_DRAW   = 3'd1,
        OP_ERASE  = 3'd2,
        OP_SCROLL = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // one result item
    typedef struct packed {
        t_op               op;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] glyph;
        logic [ROW_W-1:0]  top;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/tccs_char_if.sv
// Character channel: valid, ready and one input byte.
// Depends on tccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tccs_char_if;
    import tccs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

### hw/rtl/tccs_res_if.sv
// Result channel: valid, ready and one drawing command.
// Depends on tccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tccs_res_if;
    import tccs_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        op;
    logic [ROW_W-1:0]  screen_row;
    logic [COL_W-1:0]  screen_col;
    logic [CHAR_W-1:0] glyph;
    logic [ROW_W-1:0]  top_line;
    logic              last;

    modport source (output valid, output op, output screen_row, output screen_col,
                    output glyph, output top_line, output last, input ready);
    modport sink   (input valid, input op, input screen_row, input screen_col,
                    input glyph, input top_line, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/text_console_cursor_scroll_core.sv
// A result is offered once its character has left the execute stage register and
// been written into the result queue; the write waits until the queue has room for two.
// Throughput: one character per cycle unless a queue short of room, a register write or ring index
// reduction holds input; a scroll and draw queues two results for the single-result port.
// After a num_rows write, input waits while the ring index is reduced modulo the
// new row count, one subtraction per cycle.
// Reset (synchronous, active low) clears cursor, ring state, line length valid bits and the queue.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [tccs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [tccs_pkg::CFG_W-1:0]    i_cfg_data,
    tccs_char_if.sink                    i_char,
    tccs_res_if.source                   o_res
);
    import tccs_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // configuration
    logic [CFG_W-1:0] r_num_rows, r_num_cols;
    logic [CFG_W-1:0] rows, cols;
    logic [ROW_W-1:0] rows_m1;

    // cursor state
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_vis, n_vis;
    logic [ROW_W-1:0] r_cur, n_cur;
    logic [ROW_W-1:0] r_red;
    logic             r_busy;
    logic [ROW_W-1:0] eff_vis;

    // execute stage
    logic              r_e_valid;
    logic [CHAR_W-1:0] r_e_char;
    logic              e_fire;
    logic              accept;

    // line length memory with valid bits and forwarding
    logic [COL_W-1:0]    mem_len [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_lv;
    logic [COL_W-1:0]    r_len_q;
    logic                r_rd_vld;
    logic                r_fwd;
    logic [COL_W-1:0]    r_fwd_data;
    logic [ROW_W-1:0]    raddr;
    logic                wen;
    logic [ROW_W-1:0]    waddr;
    logic [COL_W-1:0]    wdata;
    logic [COL_W-1:0]    len_in;

    // results of the current character
    t_result res0, res1;
    logic    two_res;

    // result queue
    t_result           r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              pop;

    // top ring line: (c + rows - v) mod rows, with c and v below rows
    function automatic logic [ROW_W-1:0] top_of(input logic [ROW_W-1:0] c,
                                                input logic [ROW_W-1:0] v,
                                                input logic [CFG_W-1:0] r);
        logic [CFG_W-1:0] t;
        t = CFG_W'(c) + r - CFG_W'(v);
        if (t >= r) begin
            t = t - r;
        end
        return t[ROW_W-1:0];
    endfunction

    // clamped register values
    always_comb begin
        rows = r_num_rows;
        if (r_num_rows < ROWS_MIN) begin
            rows = ROWS_MIN;
        end else if (r_num_rows > ROWS_MAX) begin
            rows = ROWS_MAX;
        end
        cols = r_num_cols;
        if (r_num_cols < COLS_MIN) begin
            cols = COLS_MIN;
        end else if (r_num_cols > COLS_MAX) begin
            cols = COLS_MAX;
        end
    end

    assign rows_m1 = ROW_W'(rows - CFG_W'(1));
    assign eff_vis = (r_vis > rows_m1) ? rows_m1 : r_vis;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= ROWS_RST;
            r_num_cols <= COLS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_NUM_ROWS) begin
                r_num_rows <= i_cfg_data;
            end else begin
                r_num_cols <= i_cfg_data;
            end
        end
    end

    // handshake
    assign e_fire        = r_e_valid && (r_cnt <= (QPTR_W+1)'(QDEPTH - 2));
    assign i_char.ready  = !r_busy && !i_cfg_we && (!r_e_valid || e_fire);
    assign accept        = i_char.valid && i_char.ready;
    assign pop           = o_res.valid && o_res.ready;

    // operand with forwarding of a write at the read edge
    assign len_in = r_fwd ? r_fwd_data : (r_rd_vld ? r_len_q : '0);

    // execute one character
    always_comb begin
        logic             wrap;
        logic             adv;
        logic             room;
        logic [ROW_W-1:0] adv_vis;
        logic [ROW_W-1:0] adv_cur;
        logic [COL_W-1:0] col_w;
        logic [COL_W-1:0] len_w;

        wrap    = (len_in >= cols) || (r_col >= cols);
        room    = eff_vis < rows_m1;
        adv_vis = room ? eff_vis + ROW_W'(1) : eff_vis;
        adv_cur = (r_red == rows_m1) ? '0 : r_red + ROW_W'(1);
        adv     = 1'b0;

        n_col   = r_col;
        n_vis   = eff_vis;
        n_cur   = r_red;
        wen     = 1'b0;
        waddr   = r_red;
        wdata   = '0;
        two_res = 1'b0;
        col_w   = r_col;
        len_w   = len_in;

        res0 = '{op: OP_MOVE, row: eff_vis, col: '0, glyph: '0,
                 top: top_of(r_red, eff_vis, rows), last: 1'b1};
        res1 = res0;

        unique case (r_e_char)
            CH_NEWLINE: begin
                n_col = '0;
                n_vis = adv_vis;
                n_cur = adv_cur;
                wen   = 1'b1;
                waddr = adv_cur;
                res0  = '{op: room ? OP_MOVE : OP_SCROLL, row: adv_vis, col: '0,
                          glyph: '0, top: top_of(adv_cur, adv_vis, rows), last: 1'b1};
            end
            CH_BACKSPACE: begin
                if (r_col != '0) begin
                    n_col    = r_col - COL_W'(1);
                    wen      = 1'b1;
                    wdata    = (len_in != '0) ? len_in - COL_W'(1) : '0;
                    res0.op  = OP_ERASE;
                    res0.col = r_col - COL_W'(1);
                end
            end
            CH_FORMFEED: begin
                n_col = '0;
                n_vis = '0;
                n_cur = '0;
                wen   = 1'b1;
                waddr = '0;
                res0  = '{op: OP_CLEAR, row: '0, col: '0, glyph: '0,
                          top: '0, last: 1'b1};
            end
            CH_RETURN: begin
                n_col = '0;
                wen   = 1'b1;
            end
            default: begin
                // printable: wrap onto a new line first when the line is full
                adv = wrap;
                if (adv) begin
                    n_vis = adv_vis;
                    n_cur = adv_cur;
                    col_w = '0;
                    len_w = '0;
                end
                n_col = col_w + COL_W'(1);
                wen   = 1'b1;
                waddr = adv ? adv_cur : r_red;
                wdata = len_w + COL_W'(1);
                res1  = '{op: OP_DRAW, row: n_vis, col: col_w, glyph: r_e_char,
                          top: top_of(n_cur, n_vis, rows), last: 1'b1};
                two_res = adv && !room;
                res0  = two_res ? t_result'{op: OP_SCROLL, row: n_vis, col: '0, glyph: '0,
                                            top: top_of(n_cur, n_vis, rows), last: 1'b0}
                                : res1;
            end
        endcase
    end

    // memory read address follows the state the next character will see
    assign raddr = e_fire ? n_cur : r_red;

    // line length memory
    always_ff @(posedge i_clk) begin
        if (e_fire && wen) begin
            mem_len[waddr] <= wdata;
        end
        if (accept) begin
            r_len_q    <= mem_len[raddr];
            r_fwd_data <= wdata;
        end
    end

    // valid bits, read flags and forward flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv     <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (e_fire && wen) begin
                r_lv[waddr] <= 1'b1;
            end
            if (accept) begin
                r_rd_vld <= r_lv[raddr];
                r_fwd    <= e_fire && wen && (waddr == raddr);
            end
        end
    end

    // execute stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (accept) begin
            r_e_valid <= 1'b1;
        end else if (e_fire) begin
            r_e_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e_char <= i_char.char_in;
        end
    end

    // cursor state and ring index reduction after a row count change
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_vis  <= '0;
            r_cur  <= '0;
            r_red  <= '0;
            r_busy <= 1'b0;
        end else if (i_cfg_we && i_cfg_idx == CFG_NUM_ROWS) begin
            r_red  <= r_cur;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (CFG_W'(r_red) >= rows) begin
                r_red <= r_red - rows[ROW_W-1:0];
            end else begin
                r_busy <= 1'b0;
            end
        end else if (e_fire) begin
            r_col <= n_col;
            r_vis <= n_vis;
            r_cur <= n_cur;
            r_red <= n_cur;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (e_fire) begin
            r_q[r_wp] <= res0;
            if (two_res) begin
                r_q[r_wp + QPTR_W'(1)] <= res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (e_fire) begin
                r_wp <= r_wp + (two_res ? QPTR_W'(2) : QPTR_W'(1));
            end
            if (pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt
                   + (e_fire ? (two_res ? (QPTR_W+1)'(2) : (QPTR_W+1)'(1)) : '0)
                   - (pop ? (QPTR_W+1)'(1) : '0);
        end
    end

    // output transfer
    assign o_res.valid      = (r_cnt != '0);
    assign o_res.op         = r_q[r_rp].op;
    assign o_res.screen_row = r_q[r_rp].row;
    assign o_res.screen_col = r_q[r_rp].col;
    assign o_res.glyph      = r_q[r_rp].glyph;
    assign o_res.top_line   = r_q[r_rp].top;
    assign o_res.last       = r_q[r_rp].last;

endmodule

`default_nettype wire

### hw/rtl/tccs_checker.sv
// Port-level checks for the text console cursor and scroll core.
// Depends on tccs_pkg; bound to text_console_cursor_scroll_core.
`timescale 1ns / 1ps
`default_nettype none

module tccs_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_res_valid,
    input wire                        i_res_ready,
    input wire [2:0]                  i_res_op,
    input wire [tccs_pkg::ROW_W-1:0]  i_res_row,
    input wire [tccs_pkg::COL_W-1:0]  i_res_col,
    input wire [tccs_pkg::CHAR_W-1:0] i_res_glyph,
    input wire [tccs_pkg::ROW_W-1:0]  i_res_top,
    input wire                        i_res_last
);
    import tccs_pkg::*;

    // queue empty after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result offered right after reset");

    // stalled transfer stays valid and holds its op, column and last flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_op) && $stable(i_res_col) && $stable(i_res_last))
        else $error("stalled result changed");

    // clear screen homes the cursor and the ring
    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_op == OP_CLEAR |->
            i_res_row == '0 && i_res_col == '0 && i_res_top == '0 && i_res_last)
        else $error("clear screen not at home position");

    // only draw commands carry a glyph; scroll lands at column zero
    a_glyph_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_op != OP_DRAW |->
            i_res_glyph == '0 && (i_res_op != OP_SCROLL || i_res_col == '0))
        else $error("glyph or column wrong on non-draw command");

endmodule

bind text_console_cursor_scroll_core tccs_checker u_tccs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_op    (o_res.op),
    .i_res_row   (o_res.screen_row),
    .i_res_col   (o_res.screen_col),
    .i_res_glyph (o_res.glyph),
    .i_res_top   (o_res.top_line),
    .i_res_last  (o_res.last)
);

`default_nettype wire

### tb/tb_text_console_cursor_scroll_core.sv
// Self-checking bench for the text console cursor and scroll core: a console
// model predicts every drawing command and a scoreboard checks each transfer.
// Depends on tccs_pkg, tccs_char_if, tccs_res_if and the core itself.
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_core;
    import tccs_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 3000;
    localparam int ITEMS_PER_SET = 75;
    localparam int NUM_SETS      = 8;

    // console model plus the queue of commands it still expects
    class console_scoreboard;
        logic [CFG_W-1:0] rows_reg;
        logic [CFG_W-1:0] cols_reg;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] screen_line;
        logic [ROW_W-1:0] ring_line;
        logic [COL_W-1:0] line_len [MAX_ROWS];
        t_result          pending [$];
        int               errors;
        int               checked;
        int               scrolls;

        function new();
            rows_reg    = ROWS_RST;
            cols_reg    = COLS_RST;
            cursor_col  = '0;
            screen_line = '0;
            ring_line   = '0;
            foreach (line_len[i]) line_len[i] = '0;
            errors  = 0;
            checked = 0;
            scrolls = 0;
        endfunction

        function int rows_used();
            if (rows_reg < ROWS_MIN) return int'(ROWS_MIN);
            if (rows_reg > ROWS_MAX) return int'(ROWS_MAX);
            return int'(rows_reg);
        endfunction

        function int cols_used();
            if (cols_reg < COLS_MIN) return int'(COLS_MIN);
            if (cols_reg > COLS_MAX) return int'(COLS_MAX);
            return int'(cols_reg);
        endfunction

        // queue one command, top row taken from the current ring state
        function void push_cmd(t_op op, int row, int col, logic [CHAR_W-1:0] glyph,
                               int rows, bit last);
            t_result cmd;
            int      top;
            top       = (int'(ring_line) + rows - int'(screen_line)) % rows;
            cmd.op    = op;
            cmd.row   = ROW_W'(row);
            cmd.col   = COL_W'(col);
            cmd.glyph = glyph;
            cmd.top   = ROW_W'(top);
            cmd.last  = last;
            pending.push_back(cmd);
        endfunction

        // enter a fresh line, returns 1 when the screen has to scroll
        function bit open_line(int rows);
            bit scrolled;
            scrolled = 1'b0;
            if (int'(screen_line) < rows - 1) screen_line++;
            else scrolled = 1'b1;
            ring_line = ROW_W'((int'(ring_line) + 1) % rows);
            line_len[ring_line] = '0;
            cursor_col = '0;
            return scrolled;
        endfunction

        // predict the commands caused by one accepted character
        function void note_char(logic [CHAR_W-1:0] ch);
            int rows;
            int cols;
            rows = rows_used();
            cols = cols_used();
            // registers may have shrunk since the last character
            if (int'(screen_line) > rows - 1) screen_line = ROW_W'(rows - 1);
            if (int'(ring_line) >= rows) ring_line = ROW_W'(int'(ring_line) % rows);
            case (ch)
                CH_NEWLINE: begin
                    if (open_line(rows)) push_cmd(OP_SCROLL, screen_line, 0, '0, rows, 1'b1);
                    else push_cmd(OP_MOVE, screen_line, 0, '0, rows, 1'b1);
                end
                CH_BACKSPACE: begin
                    if (cursor_col == '0) begin
                        push_cmd(OP_MOVE, screen_line, 0, '0, rows, 1'b1);
                    end else begin
                        cursor_col--;
                        if (line_len[ring_line] != '0) line_len[ring_line]--;
                        push_cmd(OP_ERASE, screen_line, cursor_col, '0, rows, 1'b1);
                    end
                end
                CH_FORMFEED: begin
                    cursor_col  = '0;
                    screen_line = '0;
                    ring_line   = '0;
                    line_len[0] = '0;
                    push_cmd(OP_CLEAR, 0, 0, '0, rows, 1'b1);
                end
                CH_RETURN: begin
                    cursor_col = '0;
                    line_len[ring_line] = '0;
                    push_cmd(OP_MOVE, screen_line, 0, '0, rows, 1'b1);
                end
                default: begin
                    // full line wraps first, scrolling when the screen is full
                    if (int'(line_len[ring_line]) >= cols || int'(cursor_col) >= cols) begin
                        if (open_line(rows))
                            push_cmd(OP_SCROLL, screen_line, 0, '0, rows, 1'b0);
                    end
                    push_cmd(OP_DRAW, screen_line, cursor_col, ch, rows, 1'b1);
                    cursor_col++;
                    line_len[ring_line]++;
                end
            endcase
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("unexpected result: op %0d row %0d col %0d", got.op, got.row, got.col);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.op == OP_SCROLL) scrolls++;
            if (got.op != want.op) begin
                $error("op: expected %0d, got %0d", want.op, got.op);
                errors++;
            end
            if (got.row != want.row) begin
                $error("screen_row: expected %0d, got %0d", want.row, got.row);
                errors++;
            end
            if (got.col != want.col) begin
                $error("screen_col: expected %0d, got %0d", want.col, got.col);
                errors++;
            end
            if (got.glyph != want.glyph) begin
                $error("glyph: expected %0d, got %0d", want.glyph, got.glyph);
                errors++;
            end
            if (got.top != want.top) begin
                $error("top_line: expected %0d, got %0d", want.top, got.top);
                errors++;
            end
            if (got.last != want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // directed characters at the reset setting
    localparam logic [CHAR_W-1:0] DIR_WIDE [10] = '{
        CH_BACKSPACE, 8'h00, 8'hff, 8'h41, CH_BACKSPACE,
        CH_RETURN, CH_NEWLINE, CH_FORMFEED, 8'h80, 8'h7f
    };
    // directed characters on a two-row, one-column screen
    localparam logic [CHAR_W-1:0] DIR_NARROW [9] = '{
        8'h61, 8'h62, 8'h63, CH_NEWLINE, CH_BACKSPACE,
        8'h64, CH_BACKSPACE, CH_RETURN, CH_FORMFEED
    };
    // register settings of the random sets, the last one is drawn at random
    localparam logic [CFG_W-1:0] SET_ROWS [NUM_SETS] = '{
        7'd64, 7'd2, 7'd24, 7'd5, 7'd64, 7'd0, 7'd127, 7'd24
    };
    localparam logic [CFG_W-1:0] SET_COLS [NUM_SETS] = '{
        7'd1, 7'd84, 7'd80, 7'd3, 7'd84, 7'd0, 7'd127, 7'd80
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    tccs_char_if char_ch ();
    tccs_res_if  res_ch ();

    console_scoreboard sb = new();

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_done;
    int chars_sent;
    int settings_used;
    int stall_cycles = 0;

    text_console_cursor_scroll_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_char     (char_ch),
        .o_res      (res_ch)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        hold_done = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_done != hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // monitor both channels
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (char_ch.valid && char_ch.ready) sb.note_char(char_ch.char_in);
            if (res_ch.valid && res_ch.ready) begin
                got.op    = t_op'(res_ch.op);
                got.row   = res_ch.screen_row;
                got.col   = res_ch.screen_col;
                got.glyph = res_ch.glyph;
                got.top   = res_ch.top_line;
                got.last  = res_ch.last;
                sb.check_result(got);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // offer one character and wait for its transfer
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            char_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        char_ch.valid   <= 1'b1;
        char_ch.char_in <= ch;
        do @(posedge i_clk); while (!char_ch.ready);
        chars_sent++;
    endtask

    // stop offering and let every predicted command arrive
    task automatic wait_drained();
        char_ch.valid <= 1'b0;
        // first let the monitor note the last transfer
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write both registers while the core is idle
    task automatic set_config(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NUM_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_NUM_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.rows_reg = rows;
        sb.cols_reg = cols;
        settings_used++;
    endtask

    // any byte that is not a control code
    function automatic logic [CHAR_W-1:0] printable();
        logic [CHAR_W-1:0] ch;
        do ch = CHAR_W'($urandom_range(255));
        while (ch == CH_NEWLINE || ch == CH_BACKSPACE || ch == CH_FORMFEED || ch == CH_RETURN);
        return ch;
    endfunction

    // mostly lines of text with edits and terminators, some noise bytes
    task automatic run_random(input int count);
        int n;
        int len;
        int k;
        int pick;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                len = $urandom_range(sb.cols_used() + 2);
                for (k = 0; k < len && n < count; k++) begin
                    if ($urandom_range(9) == 0) send_char(CH_BACKSPACE);
                    else send_char(printable());
                    n++;
                end
                pick = $urandom_range(9);
                if (pick < 7) begin
                    send_char(CH_NEWLINE);
                    n++;
                end else if (pick < 9) begin
                    send_char(CH_RETURN);
                    n++;
                end
            end else if (pick < 78) begin
                send_char(CH_FORMFEED);
                n++;
            end else begin
                send_char(CHAR_W'($urandom_range(255)));
                n++;
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_NUM_ROWS;
        i_cfg_data      <= '0;
        char_ch.valid   <= 1'b0;
        char_ch.char_in <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        chars_sent     = 0;
        settings_used  = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: extremes and every control at the reset setting
        foreach (DIR_WIDE[i]) send_char(DIR_WIDE[i]);
        wait_drained();

        // directed: wraps and scrolls on the smallest screen
        set_config(7'd2, 7'd1);
        foreach (DIR_NARROW[i]) send_char(DIR_NARROW[i]);
        wait_drained();

        // random sets, state carries over so each setting change hits a live ring
        for (int s = 0; s < NUM_SETS; s++) begin
            case (s % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (s == NUM_SETS - 1)
                set_config(CFG_W'($urandom_range(2, 64)), CFG_W'($urandom_range(1, 84)));
            else
                set_config(SET_ROWS[s], SET_COLS[s]);
            // long receiver hold-off while characters keep coming
            if (s == 0) hold_req++;
            run_random(ITEMS_PER_SET);
            wait_drained();
        end

        $display("covered %0d characters over %0d register settings and four idle modes",
                 chars_sent, settings_used);
        $display("checked %0d commands, %0d of them scrolls", sb.checked, sb.scrolls);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### text_console_cursor_scroll_core.f
hw/rtl/tccs_pkg.sv
hw/rtl/tccs_char_if.sv
hw/rtl/tccs_res_if.sv
hw/rtl/text_console_cursor_scroll_core.sv
hw/rtl/tccs_checker.sv
tb/tb_text_console_cursor_scroll_core.sv
